/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define TGR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define TGR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/tgr_pkg.sv */
// Types and constants for the touch gesture recognizer.
package tgr_pkg;

  localparam int COORD_W = 10;
  localparam int TIME_W  = 48;
  localparam int SW_W    = 10;
  localparam int EZ_W    = 9;
  localparam int SLOP_W  = 10;
  localparam int US_W    = 24;
  localparam int DATA_W  = 32;

  localparam int REG_COUNT = 8;
  localparam int ADDR_W    = $clog2(REG_COUNT * 4);

  // signed working width for coordinate math and zone bounds
  localparam int VAL_W  = ((COORD_W > SW_W) ? COORD_W : SW_W) + 2;
  localparam int PROD_W = VAL_W + 4;

  localparam logic [3:0] LOCK_NUM = 4'd10;
  localparam logic [3:0] LOCK_DEN = 4'd15;
  localparam logic [4:0] DT_DIST  = 5'd26;

  typedef enum logic [$clog2(REG_COUNT)-1:0] {
    REG_SCREEN_WIDTH,
    REG_EDGE_ZONE,
    REG_TAP_SLOP,
    REG_DIRECTION_SLOP,
    REG_LOCK_DISTANCE,
    REG_FIRE_DISTANCE,
    REG_DT_MIN_US,
    REG_DT_MAX_US
  } tgr_reg_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_OPEN,
    ACT_ACCEPT,
    ACT_NEXT,
    ACT_PREV
  } tgr_action_t;

  typedef enum logic [1:0] {
    MODE_PENDING,
    MODE_SWIPE,
    MODE_CONSUMED,
    MODE_TAP
  } tgr_mode_t;

  typedef struct packed {
    logic [SW_W-1:0]   screen_width;
    logic [EZ_W-1:0]   edge_zone;
    logic [SLOP_W-1:0] tap_slop;
    logic [SLOP_W-1:0] direction_slop;
    logic [SLOP_W-1:0] lock_distance;
    logic [SLOP_W-1:0] fire_distance;
    logic [US_W-1:0]   double_tap_min_us;
    logic [US_W-1:0]   double_tap_max_us;
  } tgr_cfg_t;

  typedef struct packed {
    logic               finger_down;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [TIME_W-1:0]  now_us;
    logic               confirm_pending;
  } tgr_in_t;

  typedef struct packed {
    tgr_action_t action;
    tgr_mode_t   gesture_phase;
  } tgr_out_t;

endpackage

/* rtl/tgr_regs.sv */
// APB-style configuration register file.
module tgr_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tgr_pkg::ADDR_W-1:0] paddr,
  input  logic [tgr_pkg::DATA_W-1:0] pwdata,
  output logic [tgr_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output tgr_pkg::tgr_cfg_t          cfg
);
  import tgr_pkg::*;

  tgr_cfg_t cfg_r, cfg_nxt;
  tgr_reg_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = tgr_reg_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_SCREEN_WIDTH:   cfg_nxt.screen_width      = pwdata[SW_W-1:0];
        REG_EDGE_ZONE:      cfg_nxt.edge_zone         = pwdata[EZ_W-1:0];
        REG_TAP_SLOP:       cfg_nxt.tap_slop          = pwdata[SLOP_W-1:0];
        REG_DIRECTION_SLOP: cfg_nxt.direction_slop    = pwdata[SLOP_W-1:0];
        REG_LOCK_DISTANCE:  cfg_nxt.lock_distance     = pwdata[SLOP_W-1:0];
        REG_FIRE_DISTANCE:  cfg_nxt.fire_distance     = pwdata[SLOP_W-1:0];
        REG_DT_MIN_US:      cfg_nxt.double_tap_min_us = pwdata[US_W-1:0];
        REG_DT_MAX_US:      cfg_nxt.double_tap_max_us = pwdata[US_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SCREEN_WIDTH:   prdata = DATA_W'(cfg_r.screen_width);
      REG_EDGE_ZONE:      prdata = DATA_W'(cfg_r.edge_zone);
      REG_TAP_SLOP:       prdata = DATA_W'(cfg_r.tap_slop);
      REG_DIRECTION_SLOP: prdata = DATA_W'(cfg_r.direction_slop);
      REG_LOCK_DISTANCE:  prdata = DATA_W'(cfg_r.lock_distance);
      REG_FIRE_DISTANCE:  prdata = DATA_W'(cfg_r.fire_distance);
      REG_DT_MIN_US:      prdata = DATA_W'(cfg_r.double_tap_min_us);
      REG_DT_MAX_US:      prdata = DATA_W'(cfg_r.double_tap_max_us);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width      <= SW_W'(172);
      cfg_r.edge_zone         <= EZ_W'(44);
      cfg_r.tap_slop          <= SLOP_W'(18);
      cfg_r.direction_slop    <= SLOP_W'(10);
      cfg_r.lock_distance     <= SLOP_W'(32);
      cfg_r.fire_distance     <= SLOP_W'(40);
      cfg_r.double_tap_min_us <= US_W'(70000);
      cfg_r.double_tap_max_us <= US_W'(360000);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/tgr_core.sv */
// Gesture state, per-sample classification and the result register.
module tgr_core (
  input  logic              clk,
  input  logic              rst_n,
  input  tgr_pkg::tgr_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  tgr_pkg::tgr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tgr_pkg::tgr_out_t out_data
);
  import tgr_pkg::*;

  typedef logic signed [VAL_W-1:0] sval_t;
  typedef logic [VAL_W-1:0]        uval_t;

  function automatic sval_t to_s(input logic [COORD_W-1:0] v);
    return sval_t'(VAL_W'(v));
  endfunction

  function automatic uval_t mag(input sval_t v);
    return (v < 0) ? uval_t'(-v) : uval_t'(v);
  endfunction

  // gesture state
  logic               was_down_r, was_down_nxt;
  tgr_mode_t          mode_r, mode_nxt;
  logic               swipe_fired_r, swipe_fired_nxt;
  logic [COORD_W-1:0] press_x_r, press_x_nxt, press_y_r, press_y_nxt;
  logic [COORD_W-1:0] last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic               tap_valid_r, tap_valid_nxt;
  logic [TIME_W-1:0]  tap_time_r, tap_time_nxt;
  logic [COORD_W-1:0] tap_x_r, tap_x_nxt, tap_y_r, tap_y_nxt;

  // result register
  logic     out_valid_r, out_valid_nxt;
  tgr_out_t out_data_r, out_data_nxt;

  logic in_fire;

  sval_t      edge_s, right_s, fire_s;
  sval_t      dx_h, dy_h, dx_rel, dy_rel, lx_s;
  uval_t      adx_h, ady_h;
  logic       still, lock, fire_next, fire_prev;
  tgr_mode_t  mode_mid;
  logic       tap_ok, center, gap_ok, near, dbl;
  logic [TIME_W-1:0] gap;
  tgr_action_t act;
  tgr_mode_t   phase;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    edge_s  = sval_t'(VAL_W'(cfg.edge_zone));
    right_s = sval_t'(VAL_W'(cfg.screen_width)) - edge_s;
    fire_s  = sval_t'(VAL_W'(cfg.fire_distance));

    // held: motion of the new point from the press point
    dx_h  = to_s(in_data.pos_x) - to_s(press_x_r);
    dy_h  = to_s(in_data.pos_y) - to_s(press_y_r);
    adx_h = mag(dx_h);
    ady_h = mag(dy_h);
    still = (adx_h < uval_t'(cfg.direction_slop)) && (ady_h < uval_t'(cfg.direction_slop));
    lock  = (adx_h > uval_t'(cfg.lock_distance)) &&
            (PROD_W'(adx_h) * PROD_W'(LOCK_NUM) > PROD_W'(ady_h) * PROD_W'(LOCK_DEN));
    mode_mid = (mode_r == MODE_PENDING && !still && lock) ? MODE_SWIPE : mode_r;
    fire_next = dx_h <= -fire_s;
    fire_prev = dx_h >= fire_s;

    // release: motion of the last held point
    dx_rel = to_s(last_x_r) - to_s(press_x_r);
    dy_rel = to_s(last_y_r) - to_s(press_y_r);
    tap_ok = (mode_r == MODE_PENDING) &&
             (mag(dx_rel) < uval_t'(cfg.tap_slop)) && (mag(dy_rel) < uval_t'(cfg.tap_slop));
    lx_s   = to_s(last_x_r);
    center = (lx_s > edge_s) && (lx_s < right_s);
    gap    = in_data.now_us - tap_time_r;
    gap_ok = (gap >= TIME_W'(cfg.double_tap_min_us)) &&
             (gap <= TIME_W'(cfg.double_tap_max_us));
    near   = (mag(lx_s - to_s(tap_x_r)) <= uval_t'(DT_DIST)) &&
             (mag(to_s(last_y_r) - to_s(tap_y_r)) <= uval_t'(DT_DIST));
    dbl    = center && tap_valid_r && gap_ok && near;

    was_down_nxt    = was_down_r;
    mode_nxt        = mode_r;
    swipe_fired_nxt = swipe_fired_r;
    press_x_nxt     = press_x_r;
    press_y_nxt     = press_y_r;
    last_x_nxt      = last_x_r;
    last_y_nxt      = last_y_r;
    tap_valid_nxt   = tap_valid_r;
    tap_time_nxt    = tap_time_r;
    tap_x_nxt       = tap_x_r;
    tap_y_nxt       = tap_y_r;
    act             = ACT_NONE;
    phase           = MODE_PENDING;

    if (in_data.finger_down && !was_down_r) begin
      press_x_nxt     = in_data.pos_x;
      press_y_nxt     = in_data.pos_y;
      last_x_nxt      = in_data.pos_x;
      last_y_nxt      = in_data.pos_y;
      was_down_nxt    = 1'b1;
      swipe_fired_nxt = 1'b0;
      mode_nxt        = MODE_PENDING;
    end else if (in_data.finger_down) begin
      last_x_nxt = in_data.pos_x;
      last_y_nxt = in_data.pos_y;
      if (mode_r != MODE_CONSUMED) begin
        mode_nxt = mode_mid;
        if (mode_r == MODE_PENDING && mode_mid == MODE_SWIPE) begin
          tap_valid_nxt = 1'b0;
        end
        if (mode_mid == MODE_SWIPE && !swipe_fired_r) begin
          if (fire_next) begin
            act             = ACT_NEXT;
            swipe_fired_nxt = 1'b1;
            mode_nxt        = MODE_CONSUMED;
          end else if (fire_prev) begin
            act             = ACT_PREV;
            swipe_fired_nxt = 1'b1;
            mode_nxt        = MODE_CONSUMED;
          end
        end
      end
      phase = mode_nxt;
    end else if (was_down_r) begin
      phase = mode_r;
      if (tap_ok) begin
        phase = MODE_TAP;
        if (dbl && !in_data.confirm_pending) begin
          act           = ACT_OPEN;
          tap_valid_nxt = 1'b0;
        end else if (in_data.confirm_pending && center) begin
          act           = ACT_ACCEPT;
          tap_valid_nxt = 1'b0;
        end else if (lx_s <= edge_s) begin
          act           = ACT_PREV;
          tap_valid_nxt = 1'b0;
        end else if (lx_s >= right_s) begin
          act           = ACT_NEXT;
          tap_valid_nxt = 1'b0;
        end else if (center) begin
          tap_valid_nxt = 1'b1;
          tap_time_nxt  = in_data.now_us;
          tap_x_nxt     = last_x_r;
          tap_y_nxt     = last_y_r;
        end else begin
          tap_valid_nxt = 1'b0;
        end
      end
      was_down_nxt    = 1'b0;
      swipe_fired_nxt = 1'b0;
      mode_nxt        = MODE_PENDING;
    end

    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (in_fire) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.action        = act;
      out_data_nxt.gesture_phase = phase;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_down_r    <= 1'b0;
      mode_r        <= MODE_PENDING;
      swipe_fired_r <= 1'b0;
      tap_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        was_down_r    <= was_down_nxt;
        mode_r        <= mode_nxt;
        swipe_fired_r <= swipe_fired_nxt;
        tap_valid_r   <= tap_valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      press_x_r  <= press_x_nxt;
      press_y_r  <= press_y_nxt;
      last_x_r   <= last_x_nxt;
      last_y_r   <= last_y_nxt;
      tap_time_r <= tap_time_nxt;
      tap_x_r    <= tap_x_nxt;
      tap_y_r    <= tap_y_nxt;
    end
  end

endmodule

/* rtl/touch_gesture_recognizer_top.sv */
// Top level of the touch gesture recognizer.
//
//   channel  | handshake           | word
//   ---------+---------------------+-----------------------------------------
//   in_      | in_valid / in_ready | tgr_in_t: down, x, y, now_us, confirm
//   out_     | out_valid/out_ready | tgr_out_t: action, gesture_phase
//   config   | psel/penable/pready | 32-bit registers at byte address 4*i
//
// One sample word per cycle while in_ready is high, one result word per sample:
// the classification is a single pass of compare logic from the gesture
// state into the result register, which is valid in the following cycle.
// in_ready is high whenever the result register is empty or is being taken
// that cycle, so a stalled out_ side holds exactly one word and then stalls in_.
// Synchronous active-low reset clears the gesture state, the armed tap and
// the result valid, and loads the default register values; no clearing pass.
module touch_gesture_recognizer_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // sample channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tgr_pkg::tgr_in_t           in_data,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output tgr_pkg::tgr_out_t          out_data,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tgr_pkg::ADDR_W-1:0] paddr,
  input  logic [tgr_pkg::DATA_W-1:0] pwdata,
  output logic [tgr_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import tgr_pkg::*;

  // live register values; the user must write them only while no sample is in flight, the block does not enforce it
  tgr_cfg_t cfg;

  tgr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // press/hold/release tracking, swipe lock and tap zones
  tgr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/tgr_checker.sv */
// Port-level checks for the touch gesture recognizer, bound to the top level.
`include "assert_macros.svh"

module tgr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input tgr_pkg::tgr_out_t out_data
);
  import tgr_pkg::*;

  logic out_stall, quiet_phase, tap_action;

  assign out_stall   = out_valid && !out_ready;
  assign quiet_phase = out_valid && (out_data.gesture_phase == MODE_PENDING ||
                                     out_data.gesture_phase == MODE_SWIPE);
  assign tap_action  = out_valid && (out_data.action == ACT_OPEN ||
                                     out_data.action == ACT_ACCEPT);

  // a held result word stays put
  `TGR_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_data), "held word changed")

  // an empty result register never blocks the sample side
  `TGR_ASSERT(a_ready_empty, clk, rst_n, !out_valid |-> in_ready, "in_ready low while empty")

  // pending or swipe phases never carry an action
  `TGR_ASSERT(a_phase_quiet, clk, rst_n, quiet_phase |-> out_data.action == ACT_NONE, "quiet phase action")

  // open and accept only come from a tap release
  `TGR_ASSERT(a_tap_actions, clk, rst_n, tap_action |-> out_data.gesture_phase == MODE_TAP, "stray tap action")

  // reset empties the result register
  `TGR_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind touch_gesture_recognizer_top tgr_checker u_tgr_checker (.*);
